// ===== hdl/pfla_pkg.sv =====
// Package for the pool free-list allocator: request/response codes and sequencer states.
// No dependencies.
package pfla_pkg;

	localparam int POOL_SLOTS_DEF = 64;
	localparam int IDX_W          = 6;
	localparam int STATUS_W       = 2;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE   = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_REJECT = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_LINK,
		S_HOLD
	} state_t;

endpackage

// ===== hdl/pool_free_list_allocator.sv =====
// Pool allocator top level: slot table in one synchronous memory, head register, sequencer.
// Depends on pfla_pkg.
//
//  channel | signals                              | dir
//  req     | req_valid req_ready op slot_index    | in
//  rsp     | rsp_valid rsp_ready granted_index status | out
//
// A request is accepted in S_IDLE, where the table is read, and updates the table in S_EXEC.
// A free that inserts after the head also needs S_LINK: the table has one write port.
// After reset an S_INIT pass over every slot builds the link chain; no request is taken then.
// A finished result waits in the output register; the next request is still accepted,
// and its result waits in the sequencer until the output register frees.
module pool_free_list_allocator
	import pfla_pkg::*;
#(
	parameter int POOL_SLOTS = POOL_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic                op,
	input  logic [IDX_W-1:0]    slot_index,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [IDX_W-1:0]    granted_index,
	output logic [STATUS_W-1:0] status
);

	localparam int LW   = $clog2(POOL_SLOTS);
	localparam int XW   = (LW > IDX_W) ? LW : IDX_W;
	localparam int EW   = LW + 2;
	localparam int ACT  = LW + 1;
	localparam int LVAL = LW;
	localparam logic [LW-1:0] LAST = LW'(POOL_SLOTS - 1);

	logic [EW-1:0] mem [POOL_SLOTS];
	logic [EW-1:0] rd_a_s1, rd_b_s1;

	state_t state_q, state_d;
	logic [LW-1:0] clr_q;
	logic [LW-1:0] head_q;
	logic          head_valid_q;
	op_t           op_s1;
	logic [LW-1:0] addr_s1;
	logic          range_s1;
	logic [IDX_W-1:0]    res_gr_q;
	status_t             res_st_q;
	logic                rsp_valid_q;
	logic [IDX_W-1:0]    granted_q;
	status_t             status_q;

	logic [XW-1:0] idx_x, head_x;
	logic [LW-1:0] idx_addr, rd_addr_a;
	logic          idx_range;
	logic          out_free;
	logic          free_reject, free_front, free_insert;

	logic          mem_we;
	logic [LW-1:0] mem_wa;
	logic [EW-1:0] mem_wd;
	logic          head_we;
	logic [LW-1:0] head_d;
	logic          head_valid_d;
	logic          out_load;
	logic [IDX_W-1:0] out_gr;
	status_t          out_st;
	logic             res_load;
	logic [IDX_W-1:0] res_gr;
	status_t          res_st;

	assign idx_x     = XW'(slot_index);
	assign idx_addr  = idx_x[LW-1:0];
	assign idx_range = 32'(slot_index) < POOL_SLOTS;
	assign head_x    = XW'(head_q);
	assign rd_addr_a = (op_t'(op) == OP_ALLOC) ? head_q : idx_addr;
	assign out_free  = !rsp_valid_q || rsp_ready;

	assign free_reject = !range_s1 || (head_valid_q && addr_s1 == head_q) || !rd_a_s1[ACT];
	assign free_front  = !head_valid_q || addr_s1 < head_q;
	assign free_insert = (op_s1 == OP_FREE) && !free_reject && !free_front;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT: if (clr_q == LAST) state_d = S_IDLE;
			S_IDLE: if (req_valid) state_d = S_EXEC;
			S_EXEC: begin
				if (free_insert) state_d = S_LINK;
				else if (out_free) state_d = S_IDLE;
				else state_d = S_HOLD;
			end
			S_LINK: state_d = out_free ? S_IDLE : S_HOLD;
			S_HOLD: if (out_free) state_d = S_IDLE;
			default: state_d = S_INIT;
		endcase
	end

	// outputs
	always_comb begin
		req_ready    = 1'b0;
		mem_we       = 1'b0;
		mem_wa       = addr_s1;
		mem_wd       = '0;
		head_we      = 1'b0;
		head_d       = head_q;
		head_valid_d = head_valid_q;
		out_load     = 1'b0;
		out_gr       = res_gr_q;
		out_st       = res_st_q;
		res_load     = 1'b0;
		res_gr       = '0;
		res_st       = ST_DONE;
		case (state_q)
			S_INIT: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = {1'b0, clr_q != LAST, clr_q + LW'(1)};
			end
			S_IDLE: req_ready = 1'b1;
			S_EXEC: begin
				res_load = 1'b1;
				if (op_s1 == OP_ALLOC) begin
					if (!head_valid_q) begin
						res_st = ST_EMPTY;
					end else begin
						mem_we       = 1'b1;
						mem_wa       = head_q;
						mem_wd       = {1'b1, 1'b0, {LW{1'b0}}};
						head_we      = 1'b1;
						head_d       = rd_a_s1[LW-1:0];
						head_valid_d = rd_a_s1[LVAL];
						res_gr       = head_x[IDX_W-1:0];
					end
				end else if (free_reject) begin
					res_st = ST_REJECT;
				end else if (free_front) begin
					mem_we       = 1'b1;
					mem_wd       = {1'b0, head_valid_q, head_q};
					head_we      = 1'b1;
					head_d       = addr_s1;
					head_valid_d = 1'b1;
				end else begin
					mem_we = 1'b1;
					mem_wd = {1'b0, rd_b_s1[LVAL], rd_b_s1[LW-1:0]};
				end
				out_gr   = res_gr;
				out_st   = res_st;
				out_load = out_free && !free_insert;
			end
			S_LINK: begin
				mem_we   = 1'b1;
				mem_wa   = head_q;
				mem_wd   = {1'b0, 1'b1, addr_s1};
				out_load = out_free;
			end
			S_HOLD: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_a_s1 <= mem[rd_addr_a];
		rd_b_s1 <= mem[head_q];
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			op_s1    <= op_t'(op);
			addr_s1  <= idx_addr;
			range_s1 <= idx_range;
		end
		if (res_load) begin
			res_gr_q <= res_gr;
			res_st_q <= res_st;
		end
		if (out_load) begin
			granted_q <= out_gr;
			status_q  <= out_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_INIT;
			clr_q        <= '0;
			head_q       <= '0;
			head_valid_q <= 1'b1;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_INIT) clr_q <= clr_q + LW'(1);
			if (head_we) begin
				head_q       <= head_d;
				head_valid_q <= head_valid_d;
			end
			if (out_load) rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign granted_index = granted_q;
	assign status        = status_q;

`ifndef SYNTHESIS
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready) |=> state_q == S_EXEC)
		else $error("accepted request did not enter execute");
	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != ST_DONE) |-> granted_index == '0)
		else $error("failed request carries a slot");
	a_link_head: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LINK |-> head_valid_q)
		else $error("insert after head with empty list");
	a_init_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INIT |-> !req_ready && !rsp_valid)
		else $error("request traffic during link build");
`endif

endmodule
